// ===== rtl/tsc_pkg.sv =====
// Shared types and constants of the tilemap scroll coordinate generator.
// Used by tsc_front, tsc_cmd_fifo, tsc_back and the top level.
`default_nettype none

package tsc_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;

  // input item kinds (tuser)
  localparam logic [1:0] KIND_BUS_WRITE = 2'd0;
  localparam logic [1:0] KIND_LATCH     = 2'd1;
  localparam logic [1:0] KIND_LOOKUP    = 2'd2;

  localparam logic [1:0] LAYER_FIXED = 2'd0;
  localparam logic [1:0] LAYER_ONE   = 2'd1;
  localparam logic [1:0] LAYER_TWO   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_Y = 2'd1;

  // bus address decode
  localparam logic [13:0] CTRL_ADDR = 14'h1c80;
  localparam logic [13:0] WIN_MASK  = 14'h1c00;
  localparam logic [13:0] WIN_BASE  = 14'h1800;

  // word index inside a window (byte offset / 2)
  localparam logic [8:0] X_WORD_BASE = 9'h100;  // byte 0x200
  localparam logic [8:0] Y0_WORD     = 9'd6;    // byte 0x00c, even
  localparam logic [8:0] X_BIAS      = 9'd6;

  // control byte field codes
  localparam logic [1:0] CTRL_ROW8 = 2'd2;
  localparam logic [1:0] CTRL_ROW1 = 2'd3;

  // last latch step per mode (step 0 is the single fixed entry)
  localparam logic [8:0] LAST_ROW8   = 9'd32;
  localparam logic [8:0] LAST_ROW1   = 9'd256;
  localparam logic [8:0] LAST_COL    = 9'd64;
  localparam logic [8:0] LAST_GLOBAL = 9'd1;

  localparam logic [9:0] CLEAR_LAST = 10'd1023;

  localparam int CMDQ_PTR_W = 2;

  typedef enum logic [1:0] {
    MODE_ROW8   = 2'd0,
    MODE_ROW1   = 2'd1,
    MODE_COL    = 2'd2,
    MODE_GLOBAL = 2'd3
  } scroll_mode_t;

  typedef enum logic [1:0] {
    OP_RAM_WR  = 2'd0,
    OP_CTRL_WR = 2'd1,
    OP_LATCH   = 2'd2,
    OP_LOOKUP  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [13:0] address;
    logic [7:0]  data;
    logic [1:0]  layer;
    logic [8:0]  dest_x;
    logic [7:0]  dest_y;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_READY = 2'd1,
    ST_LATCH = 2'd2
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

// ===== rtl/tilemap_scroll_coordinate_gen_core.sv =====
// Top level of the tilemap scroll coordinate generator.
// Instantiates tsc_front, tsc_cmd_fifo and tsc_back; uses tsc_pkg.
//
// Usage:
//   in_*  : stream of items; tuser is the kind (bus write, frame latch, lookup),
//           tdata carries address, data, layer and destination pixel.
//   out_* : one word per valid lookup, src_x and src_y.
//   cfg_* : crop_x (index 0) and crop_y (index 1); write only while idle.
// A lookup goes through the queue, stage s1 and the output register to out_tvalid.
// Throughput: one lookup or bus write per clock unless the output stalls or a frame latch
//   holds the queue, set by the single table read port and the pop of the command queue.
// A frame latch holds the queue while the sequencer copies one scroll RAM word
//   per cycle into the tables: for each layer the one fixed entry, then the entries
//   that the mode sweeps.
// Reset: a clearing pass zeroes scroll RAM and tables; in_tready stays low until
//   it ends. Config writes are taken throughout.
// Receiver stall: the result is held in the output register, one more lookup
//   waits in the pipeline, and the 4-entry queue keeps accepting until full.
`default_nettype none

module tilemap_scroll_coordinate_gen_core #(
  parameter int LAYER_WIDTH  = 512,
  parameter int LAYER_HEIGHT = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [1:0]                       in_tuser,   // kind
  // address[13:0], data[21:14], layer[23:22], dest_x[32:24], dest_y[40:33]
  input  wire logic [tsc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [tsc_pkg::OUT_TDATA_W-1:0]       out_tdata,  // src_x[8:0], src_y[16:9]
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tsc_pkg::*;

  logic         q_full, push, pop, head_valid;
  cmd_t         push_cmd, head;
  back_status_t status;

  tsc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .status    (status),
    .push      (push),
    .cmd       (push_cmd)
  );

  tsc_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tsc_back #(
    .LAYER_WIDTH  (LAYER_WIDTH),
    .LAYER_HEIGHT (LAYER_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/tsc_front.sv =====
// Front end: unpacks input words, classifies them and drops items with no effect.
// Depends on tsc_pkg; feeds tsc_cmd_fifo.
`default_nettype none

module tsc_front (
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [1:0]                      in_tuser,   // kind
  // address[13:0], data[21:14], layer[23:22], dest_x[32:24], dest_y[40:33]
  input  wire logic [tsc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            q_full,
  input  wire tsc_pkg::back_status_t           status,
  output logic                                 push,
  output tsc_pkg::cmd_t                        cmd
);
  import tsc_pkg::*;

  logic keep;

  assign in_tready = !q_full && !status.clearing;

  always_comb begin
    cmd.op      = OP_LOOKUP;
    cmd.address = in_tdata[13:0];
    cmd.data    = in_tdata[21:14];
    cmd.layer   = in_tdata[23:22];
    cmd.dest_x  = in_tdata[32:24];
    cmd.dest_y  = in_tdata[40:33];
    keep        = 1'b0;
    case (in_tuser)
      KIND_BUS_WRITE: begin
        if ((in_tdata[13:0] & WIN_MASK) == WIN_BASE) begin
          cmd.op = OP_RAM_WR;
          keep   = 1'b1;
        end else if (in_tdata[13:0] == CTRL_ADDR) begin
          cmd.op = OP_CTRL_WR;
          keep   = 1'b1;
        end
      end
      KIND_LATCH: begin
        cmd.op = OP_LATCH;
        keep   = 1'b1;
      end
      KIND_LOOKUP: begin
        cmd.op = OP_LOOKUP;
        keep   = (in_tdata[23:22] inside {LAYER_FIXED, LAYER_ONE, LAYER_TWO});
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_tvalid && in_tready && keep;

endmodule

`default_nettype wire

// ===== rtl/tsc_cmd_fifo.sv =====
// Short command queue between the front end and the executing back end.
// Depends on tsc_pkg for the command word type.
`default_nettype none

module tsc_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tsc_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output tsc_pkg::cmd_t      head
);
  import tsc_pkg::*;

  localparam int Depth = 1 << CMDQ_PTR_W;
  localparam logic [CMDQ_PTR_W:0] FULL_CNT = (CMDQ_PTR_W+1)'(Depth);

  cmd_t                  mem_r [Depth];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_PTR_W:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/tsc_back.sv =====
// Back end: scroll RAM, scroll tables, frame latch sequencer and lookup pipeline.
// Depends on tsc_pkg; takes commands from tsc_cmd_fifo.
`default_nettype none

module tsc_back #(
  parameter int LAYER_WIDTH  = 512,
  parameter int LAYER_HEIGHT = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             head_valid,
  input  wire tsc_pkg::cmd_t                    head,
  output logic                                  pop,
  output tsc_pkg::back_status_t                 status,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [tsc_pkg::OUT_TDATA_W-1:0]       out_tdata   // src_x[8:0], src_y[16:9]
);
  import tsc_pkg::*;

  localparam logic [10:0] WMASK = 11'(LAYER_WIDTH - 1);
  localparam logic [10:0] HMASK = 11'(LAYER_HEIGHT - 1);

  back_state_t  state_r, state_nxt;
  logic [9:0]   clr_cnt_r;
  logic         li_r;
  logic [8:0]   step_r;

  logic [8:0]   crop_x_r;
  logic [7:0]   crop_y_r;
  logic [7:0]   ctrl_r;
  scroll_mode_t mode_r [2];
  logic [8:0]   x0_r [2];
  logic [7:0]   y0_r [2];

  // scroll RAM as even/odd byte banks so one read returns a whole word
  logic [7:0]   bank_even_r [1024];
  logic [7:0]   bank_odd_r  [1024];
  logic [7:0]   rd_even_r, rd_odd_r;
  logic [8:0]   xtab_r [512];
  logic [7:0]   ytab_r [128];
  logic [8:0]   xrd_r;
  logic [7:0]   yrd_r;

  logic         pend_v_r, pend_is_x_r, pend_odd_r;
  logic [8:0]   pend_xidx_r;
  logic [6:0]   pend_yidx_r;

  logic         s1_v_r, s1_addx_r, s1_addy_r;
  logic [10:0]  s1_sx_r, s1_sy_r;
  logic         out_v_r;
  logic [8:0]   out_sx_r;
  logic [7:0]   out_sy_r;

  // control
  logic         clearing, advance, lk_go, bank_re, bank_we_e, bank_we_o;
  logic [9:0]   bank_widx;
  logic [7:0]   bank_wdata;

  // latch decode
  logic [1:0]   lbits;
  logic         lcol;
  scroll_mode_t lmode;
  logic [8:0]   llast;
  logic         issue_more;
  logic [7:0]   lidx;
  logic [8:0]   rword;
  logic         tgt_is_x, tgt_odd;
  logic [8:0]   tgt_xidx;
  logic [6:0]   tgt_yidx;
  logic [8:0]   pval_x;
  logic [7:0]   pval_y;
  logic         x_we, y_we;
  logic [8:0]   x_widx, x_wdata;
  logic [6:0]   y_widx;
  logic [7:0]   y_wdata;

  // lookup datapath
  logic         lli;
  scroll_mode_t lkmode;
  logic [10:0]  sx0, sy0, sxg, syg, sxm, sym;
  logic [7:0]   row;
  logic [5:0]   col;
  logic [10:0]  s1_sx_nxt, s1_sy_nxt;
  logic         s1_addx_nxt, s1_addy_nxt;
  logic [10:0]  fin_sx, fin_sy;

  assign clearing        = (state_r == ST_CLEAR);
  assign status.clearing = clearing;
  assign cfg_ready       = 1'b1;
  assign advance         = !(out_v_r && !out_tready);
  assign out_tvalid      = out_v_r;
  assign out_tdata       = {7'd0, out_sy_r, out_sx_r};

  // ---------------- latch decode ----------------
  assign lbits = li_r ? ctrl_r[4:3] : ctrl_r[1:0];
  assign lcol  = li_r ? ctrl_r[5]   : ctrl_r[2];
  assign lidx  = step_r[7:0] - 8'd1;

  always_comb begin
    case (lbits)
      CTRL_ROW8: lmode = MODE_ROW8;
      CTRL_ROW1: lmode = MODE_ROW1;
      default:   lmode = lcol ? MODE_COL : MODE_GLOBAL;
    endcase
    case (lmode)
      MODE_ROW8: llast = LAST_ROW8;
      MODE_ROW1: llast = LAST_ROW1;
      MODE_COL:  llast = LAST_COL;
      default:   llast = LAST_GLOBAL;
    endcase
  end

  assign issue_more = (step_r <= llast);

  // step 0 fills the one entry the mode does not sweep; then the sweep
  always_comb begin
    rword    = X_WORD_BASE;
    tgt_is_x = 1'b1;
    tgt_odd  = 1'b0;
    tgt_xidx = {li_r, 8'd0};
    tgt_yidx = {li_r, 6'd0};
    if (step_r == 9'd0) begin
      if (lmode != MODE_COL) begin
        rword    = Y0_WORD;
        tgt_is_x = 1'b0;
      end
    end else begin
      case (lmode)
        MODE_ROW8: begin
          rword    = X_WORD_BASE | {1'b0, lidx[7:3], 3'b000};
          tgt_xidx = {li_r, lidx};
        end
        MODE_ROW1: begin
          rword    = X_WORD_BASE | {1'b0, lidx};
          tgt_xidx = {li_r, lidx};
        end
        MODE_COL: begin
          rword    = {4'd0, lidx[5:1]};
          tgt_is_x = 1'b0;
          tgt_odd  = lidx[0];
          tgt_yidx = {li_r, lidx[5:0]};
        end
        default: rword = X_WORD_BASE;
      endcase
    end
  end

  assign pval_x = {rd_odd_r[0], rd_even_r} - X_BIAS;
  assign pval_y = pend_odd_r ? rd_odd_r : rd_even_r;

  // ---------------- lookup datapath ----------------
  assign lli    = head.layer[1];
  assign lkmode = mode_r[lli];
  assign sx0    = {2'd0, head.dest_x} + {2'd0, crop_x_r};
  assign sy0    = {3'd0, head.dest_y} + {3'd0, crop_y_r};
  assign sxg    = sx0 + {2'd0, x0_r[lli]};
  assign syg    = sy0 + {3'd0, y0_r[lli]};
  assign sxm    = sxg & WMASK;
  assign sym    = syg & HMASK;
  assign col    = sxm[8:3];
  assign row    = (lkmode == MODE_ROW8) ? sym[10:3] : sym[7:0];

  always_comb begin
    s1_sx_nxt   = sx0;
    s1_sy_nxt   = sy0;
    s1_addx_nxt = 1'b0;
    s1_addy_nxt = 1'b0;
    if (head.layer != LAYER_FIXED) begin
      case (lkmode)
        MODE_GLOBAL: begin
          s1_sx_nxt = sxg;
          s1_sy_nxt = syg;
        end
        MODE_COL: begin
          s1_sx_nxt   = sxm;
          s1_addy_nxt = 1'b1;
        end
        default: begin
          s1_sy_nxt   = sym;
          s1_addx_nxt = 1'b1;
        end
      endcase
    end
  end

  assign fin_sx = (s1_sx_r + (s1_addx_r ? {2'd0, xrd_r} : 11'd0)) & WMASK;
  assign fin_sy = (s1_sy_r + (s1_addy_r ? {3'd0, yrd_r} : 11'd0)) & HMASK;

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == CLEAR_LAST) state_nxt = ST_READY;
      ST_READY: if (head_valid && head.op == OP_LATCH) state_nxt = ST_LATCH;
      ST_LATCH: if (!issue_more && li_r) state_nxt = ST_READY;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    lk_go      = 1'b0;
    bank_re    = 1'b0;
    bank_we_e  = 1'b0;
    bank_we_o  = 1'b0;
    bank_widx  = {head.address[13], head.address[9:1]};
    bank_wdata = head.data;
    case (state_r)
      ST_CLEAR: begin
        bank_we_e  = 1'b1;
        bank_we_o  = 1'b1;
        bank_widx  = clr_cnt_r;
        bank_wdata = 8'd0;
      end
      ST_READY: begin
        if (head_valid) begin
          case (head.op)
            OP_LOOKUP: begin
              pop   = advance;
              lk_go = advance;
            end
            OP_RAM_WR: begin
              pop       = 1'b1;
              bank_we_e = !head.address[0];
              bank_we_o = head.address[0];
            end
            OP_CTRL_WR: pop = 1'b1;
            OP_LATCH:   pop = 1'b1;
            default:    pop = 1'b0;
          endcase
        end
      end
      ST_LATCH: bank_re = issue_more;
      default: pop = 1'b0;
    endcase
  end

  assign x_we    = clearing || (pend_v_r && pend_is_x_r);
  assign x_widx  = clearing ? clr_cnt_r[8:0] : pend_xidx_r;
  assign x_wdata = clearing ? 9'd0 : pval_x;
  assign y_we    = clearing || (pend_v_r && !pend_is_x_r);
  assign y_widx  = clearing ? clr_cnt_r[6:0] : pend_yidx_r;
  assign y_wdata = clearing ? 8'd0 : pval_y;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      li_r      <= 1'b0;
      step_r    <= '0;
      pend_v_r  <= 1'b0;
      crop_x_r  <= '0;
      crop_y_r  <= '0;
      ctrl_r    <= '0;
      mode_r[0] <= MODE_GLOBAL;
      mode_r[1] <= MODE_GLOBAL;
      x0_r[0]   <= '0;
      x0_r[1]   <= '0;
      y0_r[0]   <= '0;
      y0_r[1]   <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= bank_re;
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_CROP_X: crop_x_r <= cfg_data[8:0];
          CFG_CROP_Y: crop_y_r <= cfg_data[7:0];
          default:    ;
        endcase
      end

      if (pop && head.op == OP_CTRL_WR) ctrl_r <= head.data;

      if (pop && head.op == OP_LATCH) begin
        li_r   <= 1'b0;
        step_r <= '0;
      end else if (state_r == ST_LATCH) begin
        if (issue_more) begin
          step_r <= step_r + 1'b1;
          if (step_r == 9'd0) mode_r[li_r] <= lmode;
        end else if (!li_r) begin
          li_r   <= 1'b1;
          step_r <= '0;
        end
      end

      // entry 0 of each table is mirrored for the first-level add
      if (pend_v_r && pend_is_x_r && pend_xidx_r[7:0] == 8'd0)
        x0_r[pend_xidx_r[8]] <= pval_x;
      if (pend_v_r && !pend_is_x_r && pend_yidx_r[5:0] == 6'd0)
        y0_r[pend_yidx_r[6]] <= pval_y;

      if (advance) begin
        s1_v_r  <= lk_go;
        out_v_r <= s1_v_r;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (bank_re) begin
      pend_is_x_r <= tgt_is_x;
      pend_odd_r  <= tgt_odd;
      pend_xidx_r <= tgt_xidx;
      pend_yidx_r <= tgt_yidx;
    end
    if (advance) begin
      if (lk_go) begin
        s1_sx_r   <= s1_sx_nxt;
        s1_sy_r   <= s1_sy_nxt;
        s1_addx_r <= s1_addx_nxt;
        s1_addy_r <= s1_addy_nxt;
      end
      out_sx_r <= fin_sx[8:0];
      out_sy_r <= fin_sy[7:0];
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (bank_we_e) bank_even_r[bank_widx] <= bank_wdata;
    if (bank_we_o) bank_odd_r[bank_widx]  <= bank_wdata;
    if (bank_re) begin
      rd_even_r <= bank_even_r[{li_r, rword}];
      rd_odd_r  <= bank_odd_r[{li_r, rword}];
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) xtab_r[x_widx] <= x_wdata;
    if (lk_go) xrd_r <= xtab_r[{lli, row}];
  end

  always_ff @(posedge clk) begin
    if (y_we) ytab_r[y_widx] <= y_wdata;
    if (lk_go) yrd_r <= ytab_r[{lli, col}];
  end

`ifndef SYNTHESIS
  a_pop_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_READY)
    else $error("command popped outside ready state");

  a_pend_in_latch: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> state_r == ST_LATCH)
    else $error("table write pending outside frame latch");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |=> (s1_v_r && $stable(s1_sx_r) && $stable(s1_sy_r)))
    else $error("lookup stage lost while output stalled");

  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> state_r != ST_CLEAR)
    else $error("result shown during clearing pass");
`endif

endmodule

`default_nettype wire
